// ===== rtl/core/gbfp_pkg.sv =====
// shared types, constants and codes of the binary frame parser
`timescale 1ns / 1ps

package gbfp_pkg;

	localparam int WATCH_SLOTS_DEF       = 8;
	localparam int MAX_PAYLOAD_BOUND_DEF = 4096;

	localparam int BYTE_W     = 8;
	localparam int COUNT_W    = 13;
	localparam int LEN_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam int S_DATA_W   = 24;
	localparam int M_DATA_W   = 48;

	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_ARM  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ACK_CLASS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'b1;

	localparam logic [7:0]         ACK_CLASS_RESET   = 8'd5;
	localparam logic [COUNT_W-1:0] MAX_PAYLOAD_RESET = 13'd256;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SYNC2,
		PH_CLASS,
		PH_ID,
		PH_LEN0,
		PH_LEN1,
		PH_PAYLOAD,
		PH_CKA,
		PH_CKB
	} phase_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic sum_en;
		logic sync_clr;
		logic ld_class;
		logic ld_id;
		logic ld_len0;
		logic ld_len1;
		logic pay_take;
		logic res_bad;
		logic res_ok;
		logic arm;
	} dp_cmd_t;

	typedef struct packed {
		logic func;
		logic is_sync1;
		logic is_sync2;
		logic len_zero;
		logic at_limit;
		logic last_byte;
		logic cka_ok;
		logic ckb_ok;
	} dp_stat_t;

	typedef struct packed {
		logic       frame_done;
		logic       checksum_bad;
		logic [7:0] frame_class;
		logic [7:0] frame_id;
		logic       ack_hit;
		logic [7:0] ack_class;
		logic [7:0] ack_msg_id;
		logic [7:0] ack_kind;
		logic       table_full;
	} result_t;

endpackage

// ===== rtl/core/gbfp_ctrl.sv =====
// frame phase state machine and item handshake control
`timescale 1ns / 1ps

module gbfp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  gbfp_pkg::dp_stat_t stat,
	output gbfp_pkg::dp_cmd_t  cmd
);
	import gbfp_pkg::*;

	phase_t phase_q;
	phase_t phase_d;
	logic   busy_q;
	logic   out_valid_q;
	logic   exec;

	assign s_tready = ~busy_q;
	assign m_tvalid = out_valid_q;
	assign exec     = busy_q & (~out_valid_q | m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (s_tvalid && !busy_q) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (exec && stat.func == FUNC_BYTE) begin
			if (stat.is_sync1) begin
				phase_d = PH_SYNC2;
			end else begin
				case (phase_q)
					PH_SYNC2:   phase_d = stat.is_sync2 ? PH_CLASS : PH_IDLE;
					PH_CLASS:   phase_d = PH_ID;
					PH_ID:      phase_d = PH_LEN0;
					PH_LEN0:    phase_d = PH_LEN1;
					PH_LEN1:    phase_d = stat.len_zero ? PH_CKA : PH_PAYLOAD;
					PH_PAYLOAD: begin
						if (stat.at_limit) begin
							phase_d = PH_IDLE;
						end else if (stat.last_byte) begin
							phase_d = PH_CKA;
						end
					end
					PH_CKA:     phase_d = stat.cka_ok ? PH_CKB : PH_IDLE;
					PH_CKB:     phase_d = PH_IDLE;
					default:    phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// datapath commands
	always_comb begin
		cmd         = '0;
		cmd.load_in = s_tvalid & ~busy_q;
		cmd.exec    = exec;
		if (exec) begin
			if (stat.func == FUNC_ARM) begin
				cmd.arm = 1'b1;
			end else if (!stat.is_sync1) begin
				case (phase_q)
					PH_SYNC2:   cmd.sync_clr = stat.is_sync2;
					PH_CLASS: begin
						cmd.sum_en   = 1'b1;
						cmd.ld_class = 1'b1;
					end
					PH_ID: begin
						cmd.sum_en = 1'b1;
						cmd.ld_id  = 1'b1;
					end
					PH_LEN0: begin
						cmd.sum_en  = 1'b1;
						cmd.ld_len0 = 1'b1;
					end
					PH_LEN1: begin
						cmd.sum_en  = 1'b1;
						cmd.ld_len1 = 1'b1;
					end
					PH_PAYLOAD: begin
						cmd.sum_en   = 1'b1;
						cmd.pay_take = ~stat.at_limit;
					end
					PH_CKA:     cmd.res_bad = ~stat.cka_ok;
					PH_CKB: begin
						cmd.res_ok  = stat.ckb_ok;
						cmd.res_bad = ~stat.ckb_ok;
					end
					default:    cmd.sum_en = 1'b0;
				endcase
			end
		end
	end

endmodule

// ===== rtl/core/gbfp_dp.sv =====
// datapath: checksums, frame fields, watch table and result register
`timescale 1ns / 1ps

module gbfp_dp #(
	parameter int WATCH_SLOTS       = gbfp_pkg::WATCH_SLOTS_DEF,
	parameter int MAX_PAYLOAD_BOUND = gbfp_pkg::MAX_PAYLOAD_BOUND_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gbfp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gbfp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                in_func,
	input  logic [7:0]                          in_rx_byte,
	input  logic [7:0]                          in_watch_class,
	input  logic [7:0]                          in_watch_id,
	input  gbfp_pkg::dp_cmd_t                   cmd,
	output gbfp_pkg::dp_stat_t                  stat,
	output gbfp_pkg::result_t                   res
);
	import gbfp_pkg::*;

	localparam logic [16:0] BOUND = 17'(MAX_PAYLOAD_BOUND);

	logic               func_q;
	logic [7:0]         byte_q;
	logic [7:0]         wcls_q;
	logic [7:0]         wid_q;
	logic [7:0]         ack_code_q;
	logic [COUNT_W-1:0] max_pay_q;
	logic [7:0]         sum_a_q;
	logic [7:0]         sum_b_q;
	logic [7:0]         cls_q;
	logic [7:0]         id_q;
	logic [LEN_W-1:0]   len_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [7:0]         first_q [2];
	logic [WATCH_SLOTS-1:0] armed_q;
	logic [7:0]         slot_cls_q [WATCH_SLOTS];
	logic [7:0]         slot_id_q [WATCH_SLOTS];
	result_t            res_q;
	result_t            res_d;

	logic [7:0]  sum_a_n;
	logic [7:0]  sum_b_n;
	logic [16:0] max_ext;
	logic [16:0] limit;
	logic [16:0] cnt_inc;

	logic [WATCH_SLOTS-1:0] arm_cand;
	logic [WATCH_SLOTS-1:0] arm_first;
	logic [WATCH_SLOTS-1:0] armed_arm_n;
	logic [WATCH_SLOTS-1:0] hit;
	logic [WATCH_SLOTS-1:0] hit_first;
	logic                   ack_frame;
	logic                   ack_match;

	assign sum_a_n = sum_a_q + byte_q;
	assign sum_b_n = sum_b_q + sum_a_n;
	assign max_ext = 17'(max_pay_q);
	assign limit   = (max_ext > BOUND) ? BOUND : max_ext;
	assign cnt_inc = 17'(cnt_q) + 17'd1;

	always_comb begin
		stat           = '0;
		stat.func      = func_q;
		stat.is_sync1  = (byte_q == SYNC_FIRST);
		stat.is_sync2  = (byte_q == SYNC_SECOND);
		stat.len_zero  = (byte_q == 8'd0) && (len_q[7:0] == 8'd0);
		stat.at_limit  = (17'(cnt_q) >= limit);
		stat.last_byte = (cnt_inc >= 17'(len_q));
		stat.cka_ok    = (sum_a_q == byte_q);
		stat.ckb_ok    = (sum_b_q == byte_q);
	end

	// arming: first free or same-key slot takes the key, later same-key slots drop
	always_comb begin
		logic found;
		found       = 1'b0;
		arm_first   = '0;
		armed_arm_n = armed_q;
		for (int i = 0; i < WATCH_SLOTS; i++) begin
			arm_cand[i] = ~armed_q[i] | ((slot_cls_q[i] == wcls_q) && (slot_id_q[i] == wid_q));
			if (arm_cand[i]) begin
				arm_first[i]   = ~found;
				armed_arm_n[i] = ~found;
				found          = 1'b1;
			end
		end
	end

	// acknowledge lookup: first armed slot matching payload bytes 0 and 1
	always_comb begin
		logic found;
		found     = 1'b0;
		hit_first = '0;
		for (int i = 0; i < WATCH_SLOTS; i++) begin
			hit[i] = armed_q[i] && (slot_cls_q[i] == first_q[0]) && (slot_id_q[i] == first_q[1]);
			if (hit[i] && !found) begin
				hit_first[i] = 1'b1;
				found        = 1'b1;
			end
		end
	end

	assign ack_frame = (cls_q == ack_code_q);
	assign ack_match = cmd.res_ok & ack_frame & (|hit);

	always_comb begin
		res_d = '0;
		if (cmd.res_ok) begin
			res_d.frame_done  = 1'b1;
			res_d.frame_class = cls_q;
			res_d.frame_id    = id_q;
		end
		if (ack_match) begin
			res_d.ack_hit    = 1'b1;
			res_d.ack_class  = first_q[0];
			res_d.ack_msg_id = first_q[1];
			res_d.ack_kind   = id_q;
		end
		res_d.checksum_bad = cmd.res_bad;
		if (cmd.arm) begin
			res_d.table_full = ~(|arm_cand);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= in_func;
			byte_q <= in_rx_byte;
			wcls_q <= in_watch_class;
			wid_q  <= in_watch_id;
		end
		if (cmd.pay_take && cnt_q < COUNT_W'(2)) begin
			first_q[cnt_q[0]] <= byte_q;
		end
		for (int i = 0; i < WATCH_SLOTS; i++) begin
			if (cmd.arm && arm_first[i]) begin
				slot_cls_q[i] <= wcls_q;
				slot_id_q[i]  <= wid_q;
			end
		end
		if (cmd.exec) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_code_q <= ACK_CLASS_RESET;
			max_pay_q  <= MAX_PAYLOAD_RESET;
			sum_a_q    <= '0;
			sum_b_q    <= '0;
			cls_q      <= '0;
			id_q       <= '0;
			len_q      <= '0;
			cnt_q      <= '0;
			armed_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ACK_CLASS:   ack_code_q <= cfg_wdata[7:0];
					CFG_MAX_PAYLOAD: max_pay_q  <= cfg_wdata;
					default:         ack_code_q <= ack_code_q;
				endcase
			end
			if (cmd.sync_clr) begin
				sum_a_q <= '0;
				sum_b_q <= '0;
				cnt_q   <= '0;
			end else if (cmd.sum_en) begin
				sum_a_q <= sum_a_n;
				sum_b_q <= sum_b_n;
			end
			if (cmd.ld_class) begin
				cls_q <= byte_q;
			end
			if (cmd.ld_id) begin
				id_q <= byte_q;
			end
			if (cmd.ld_len0) begin
				len_q <= {8'd0, byte_q};
			end
			if (cmd.ld_len1) begin
				len_q <= {byte_q, len_q[7:0]};
			end
			if (cmd.pay_take) begin
				cnt_q <= cnt_q + COUNT_W'(1);
			end
			if (cmd.arm) begin
				armed_q <= armed_arm_n;
			end else if (ack_match) begin
				armed_q <= armed_q & ~hit_first;
			end
		end
	end

	assign res = res_q;

endmodule

// ===== rtl/core/gnss_binary_frame_parser_unit.sv =====
// top level of the binary frame parser with acknowledge watch table
// an accepted item is captured, then executed, and its result is registered onto m_tvalid
// one item in flight: s_tready stays low from capture until the controller executes the item
// a stalled m_tready holds the result and keeps the next item waiting in its capture register
// reset: parser idle, sums and counts zero, all watch slots disarmed, registers 5 and 256
// slot keys and payload bytes 0 and 1 are not reset and need no clearing pass
`timescale 1ns / 1ps

module gnss_binary_frame_parser_unit #(
	parameter int WATCH_SLOTS       = gbfp_pkg::WATCH_SLOTS_DEF,
	parameter int MAX_PAYLOAD_BOUND = gbfp_pkg::MAX_PAYLOAD_BOUND_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// rx_byte, watch_class, watch_id
	input  logic [gbfp_pkg::S_DATA_W-1:0]   s_tdata,
	// func
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// frame_done, checksum_bad, frame_class, frame_id, ack_hit, ack_class,
	// ack_msg_id, ack_kind, table_full, zero fill
	output logic [gbfp_pkg::M_DATA_W-1:0]   m_tdata,
	input  logic                            cfg_we,
	input  logic [gbfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gbfp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import gbfp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	result_t  res;

	gbfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gbfp_dp #(
		.WATCH_SLOTS       (WATCH_SLOTS),
		.MAX_PAYLOAD_BOUND (MAX_PAYLOAD_BOUND)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_func        (s_tuser),
		.in_rx_byte     (s_tdata[7:0]),
		.in_watch_class (s_tdata[15:8]),
		.in_watch_id    (s_tdata[23:16]),
		.cmd            (cmd),
		.stat           (stat),
		.res            (res)
	);

	assign m_tdata = {4'd0, res.table_full, res.ack_kind, res.ack_msg_id, res.ack_class,
		res.ack_hit, res.frame_id, res.frame_class, res.checksum_bad, res.frame_done};

	a_one_item_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while previous item still executing");

	a_done_bad_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res.frame_done && res.checksum_bad))
		else $error("frame reported both passed and failed");

	a_hit_needs_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.ack_hit) |-> res.frame_done)
		else $error("acknowledge hit without a completed frame");

	a_full_only_on_arm: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.table_full) |-> (!res.frame_done && !res.checksum_bad))
		else $error("table full flagged on a received byte");

endmodule
